@@ rtl/fds_pkg.sv @@
// ----------------------------------------------------------------------------
// fds_pkg
// Shared types and codes for the frame duration sequencer.
// ----------------------------------------------------------------------------
package fds_pkg;

    localparam int DUR_W   = 16;
    localparam int FIDX_W  = 6;
    localparam int FCNT_W  = 7;
    localparam int MODE_W  = 2;
    localparam int TABLE_LIM = 64;

    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

    localparam logic REG_LOOP_ENABLE = 1'b0;
    localparam logic REG_FRAME_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_EMIT
    } fds_state_t;

    typedef struct packed {
        logic              loop_enable;
        logic [FCNT_W-1:0] frame_count;
    } fds_cfg_t;

    typedef struct packed {
        logic              done_res;
        logic [DUR_W-1:0]  time_in_frame;
        logic [FIDX_W-1:0] frame_now;
    } fds_result_t;

endpackage

@@ rtl/fds_dur_ram.sv @@
// ----------------------------------------------------------------------------
// fds_dur_ram
// Duration table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fds_dur_ram
    import fds_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [DUR_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [DUR_W-1:0] rd_data
);

    logic [DUR_W-1:0] mem [0:DEPTH-1];
    logic [DUR_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/fds_seq_ctrl.sv @@
// ----------------------------------------------------------------------------
// fds_seq_ctrl
// Sequencer control: decodes items, walks the duration table one frame a read.
// ----------------------------------------------------------------------------
module fds_seq_ctrl
    import fds_pkg::*;
#(
    parameter int MAX_FRAMES = 64,
    parameter int AW         = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [MODE_W-1:0] s_mode,
    input  logic [FIDX_W-1:0] s_frame_index,
    input  logic [DUR_W-1:0]  s_frame_dur,
    input  logic [DUR_W-1:0]  s_dt_ms,
    input  fds_cfg_t          cfg,
    input  logic              out_free,
    output logic              res_load,
    output fds_result_t       res,
    output logic              ram_wr_en,
    output logic [AW-1:0]     ram_wr_addr,
    output logic [DUR_W-1:0]  ram_wr_data,
    output logic              ram_rd_en,
    output logic [AW-1:0]     ram_rd_addr,
    input  logic [DUR_W-1:0]  ram_rd_data
);

    localparam int LIM = (MAX_FRAMES < TABLE_LIM) ? MAX_FRAMES : TABLE_LIM;
    localparam int IW  = ((AW > FIDX_W) ? AW : FIDX_W) + 1;

    fds_state_t        state_reg, state_next;
    logic [FIDX_W-1:0] idx_reg, idx_next;
    logic [DUR_W-1:0]  elapsed_reg, elapsed_next;
    logic [DUR_W-1:0]  rem_reg, rem_next;
    logic              fin_reg, fin_next;

    logic [FCNT_W-1:0] n_use;
    logic [FCNT_W-1:0] n_last;
    logic              accept;
    logic [IW-1:0]     wr_idx_ext;
    logic [IW-1:0]     rd_idx_ext;

    logic [DUR_W-1:0]  dur;
    logic [DUR_W:0]    sum;
    logic [FCNT_W-1:0] idx_inc;

    logic              acc_fin;
    logic              acc_go;
    logic              ev_stop;

    assign n_use  = (cfg.frame_count > FCNT_W'(LIM)) ? FCNT_W'(LIM) : cfg.frame_count;
    assign n_last = n_use - FCNT_W'(1);
    assign accept = s_tvalid && s_tready;

    assign wr_idx_ext  = IW'(s_frame_index);
    assign rd_idx_ext  = IW'(idx_reg);
    assign ram_wr_addr = wr_idx_ext[AW-1:0];
    assign ram_wr_data = (s_frame_dur == '0) ? DUR_W'(1) : s_frame_dur;
    assign ram_rd_addr = rd_idx_ext[AW-1:0];

    assign dur     = (ram_rd_data == '0) ? DUR_W'(1) : ram_rd_data;
    assign sum     = {1'b0, elapsed_reg} + {1'b0, rem_reg};
    assign idx_inc = {1'b0, idx_reg} + FCNT_W'(1);

    assign acc_fin = fin_reg || (n_use == '0);
    assign acc_go  = !acc_fin && (s_dt_ms != '0);

    // Datapath step
    always_comb begin
        idx_next     = idx_reg;
        elapsed_next = elapsed_reg;
        rem_next     = rem_reg;
        fin_next     = fin_reg;
        ev_stop      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_mode)
                        MODE_TICK: begin
                            if (acc_fin) begin
                                fin_next = 1'b1;
                            end else begin
                                if ({1'b0, idx_reg} >= n_use) begin
                                    idx_next = n_last[FIDX_W-1:0];
                                end
                                rem_next = s_dt_ms;
                            end
                        end
                        MODE_RESTART: begin
                            idx_next     = '0;
                            elapsed_next = '0;
                            fin_next     = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EVAL: begin
                if (sum < {1'b0, dur}) begin
                    elapsed_next = sum[DUR_W-1:0];
                    rem_next     = '0;
                    ev_stop      = 1'b1;
                end else begin
                    if (elapsed_reg < dur) begin
                        rem_next = rem_reg - (dur - elapsed_reg);
                    end
                    elapsed_next = '0;
                    if (idx_inc >= n_use) begin
                        if (cfg.loop_enable) begin
                            idx_next = '0;
                        end else begin
                            idx_next = n_last[FIDX_W-1:0];
                            fin_next = 1'b1;
                        end
                    end else begin
                        idx_next = idx_inc[FIDX_W-1:0];
                    end
                    ev_stop = (rem_next == '0) || fin_next;
                end
            end
            default: begin
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if ((s_mode == MODE_TICK) && acc_go) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                state_next = ev_stop ? ST_EMIT : ST_READ;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_tready  = 1'b0;
        ram_wr_en = 1'b0;
        ram_rd_en = 1'b0;
        res_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                ram_wr_en = s_tvalid && (s_mode == MODE_WRITE)
                            && (wr_idx_ext < IW'(MAX_FRAMES));
            end
            ST_READ: begin
                ram_rd_en = 1'b1;
            end
            ST_EMIT: begin
                res_load = out_free;
            end
            default: begin
            end
        endcase
    end

    assign res.frame_now     = idx_reg;
    assign res.time_in_frame = elapsed_reg;
    assign res.done_res      = fin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            elapsed_reg <= '0;
            fin_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            elapsed_reg <= elapsed_next;
            fin_reg     <= fin_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
    end

endmodule

@@ rtl/frame_duration_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// frame_duration_sequencer_top
// Frame duration sequencer with stream ports and a register write port.
// ----------------------------------------------------------------------------
// Every item gives one result: the current frame, the time spent in it and
// the finished flag after the item. Write, restart and unknown items present
// their result 1 cycle after acceptance and the next item can be taken one
// cycle after that; a tick passes through a READ and then an EVAL state for
// each duration table read it needs (one per frame it enters or ends, at
// least one for a non-zero tick that is not already finished) before it
// presents its result, and then the next item can be taken. The table read
// is registered, hence the READ state before each EVAL. One item is worked on
// at a time; a result waiting in the output register does not stop the next
// item being taken, but that item's result waits until the register is free.
// Table entries are undefined until written.
module frame_duration_sequencer_top
    import fds_pkg::*;
#(
    parameter int MAX_FRAMES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // frame_index[5:0], frame_dur[21:6], dt_ms[37:22]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // frame_now[5:0], time_in_frame[21:6], done_res[22]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata
);

    localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    fds_cfg_t         cfg_reg;
    fds_result_t      res;
    logic             res_load;
    logic             out_free;
    logic             m_tvalid_reg;
    logic [23:0]      m_tdata_reg;

    logic             ram_wr_en;
    logic [AW-1:0]    ram_wr_addr;
    logic [DUR_W-1:0] ram_wr_data;
    logic             ram_rd_en;
    logic [AW-1:0]    ram_rd_addr;
    logic [DUR_W-1:0] ram_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.loop_enable <= 1'b1;
            cfg_reg.frame_count <= FCNT_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LOOP_ENABLE: cfg_reg.loop_enable <= cfg_wdata[0];
                REG_FRAME_COUNT: cfg_reg.frame_count <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    fds_seq_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .AW         (AW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_mode        (s_tuser),
        .s_frame_index (s_tdata[5:0]),
        .s_frame_dur   (s_tdata[21:6]),
        .s_dt_ms       (s_tdata[37:22]),
        .cfg           (cfg_reg),
        .out_free      (out_free),
        .res_load      (res_load),
        .res           (res),
        .ram_wr_en     (ram_wr_en),
        .ram_wr_addr   (ram_wr_addr),
        .ram_wr_data   (ram_wr_data),
        .ram_rd_en     (ram_rd_en),
        .ram_rd_addr   (ram_rd_addr),
        .ram_rd_data   (ram_rd_data)
    );

    fds_dur_ram #(
        .DEPTH (MAX_FRAMES),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_tdata_reg <= {1'b0, res.done_res, res.time_in_frame, res.frame_now};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ rtl/fds_checker.sv @@
// ----------------------------------------------------------------------------
// fds_checker
// Port-level checks on the frame duration sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module fds_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while another is in work");

    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without an item in work");

endmodule

bind frame_duration_sequencer_top fds_checker u_fds_checker (.*);

@@ dv/fds_sequence_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fds_sequence_checker
// Watches the item, result and register ports of the frame duration
// sequencer, keeps its own copy of the duration table, frame position and
// finished flag, predicts the result of every accepted item and compares
// each returned result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module fds_sequence_checker
    import fds_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata,
    output int          mismatch_count,
    output int          results_owed
);

    logic [DUR_W-1:0]  dur_tbl [TABLE_LIM];
    logic [FIDX_W-1:0] cur_frame;
    logic [DUR_W-1:0]  spent;
    logic              fin;
    logic              loop_en;
    logic [FCNT_W-1:0] fcount;
    fds_result_t       expected_frames [$];

    task automatic advance_frames(input logic [DUR_W-1:0] dt);
        int n;
        int left;
        int dur;
        int used;
        n    = (fcount > TABLE_LIM) ? TABLE_LIM : int'(fcount);
        left = dt;
        used = spent;
        if (fin || n == 0) begin
            fin = 1'b1;
            return;
        end
        if (cur_frame >= n) cur_frame = FIDX_W'(n - 1);
        while (left > 0 && !fin) begin
            dur = dur_tbl[cur_frame];
            if (dur == 0) dur = 1;
            if (used + left < dur) begin
                used = used + left;
                left = 0;
            end else begin
                if (used < dur) left = left - (dur - used);
                used = 0;
                if (int'(cur_frame) + 1 >= n) begin
                    if (loop_en) begin
                        cur_frame = '0;
                    end else begin
                        cur_frame = FIDX_W'(n - 1);
                        fin = 1'b1;
                    end
                end else begin
                    cur_frame = cur_frame + 1'b1;
                end
            end
        end
        spent = DUR_W'(used);
    endtask

    always @(posedge aclk) begin
        fds_result_t       got;
        fds_result_t       want;
        logic [MODE_W-1:0] mode;
        logic [FIDX_W-1:0] idx;
        logic [DUR_W-1:0]  dur;
        logic [DUR_W-1:0]  dt;
        if (!aresetn) begin
            cur_frame = '0;
            spent = '0;
            fin = 1'b0;
            loop_en = 1'b1;
            fcount = FCNT_W'(1);
            mismatch_count = 0;
            expected_frames.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.frame_now     = m_tdata[5:0];
                got.time_in_frame = m_tdata[21:6];
                got.done_res      = m_tdata[22];
                if (expected_frames.size() == 0) begin
                    $error("result with none expected: frame_now %0d time_in_frame %0d",
                           got.frame_now, got.time_in_frame);
                    mismatch_count++;
                end else begin
                    want = expected_frames.pop_front();
                    if (got.frame_now !== want.frame_now) begin
                        $error("frame_now expected %0d actual %0d",
                               want.frame_now, got.frame_now);
                        mismatch_count++;
                    end
                    if (got.time_in_frame !== want.time_in_frame) begin
                        $error("time_in_frame expected %0d actual %0d",
                               want.time_in_frame, got.time_in_frame);
                        mismatch_count++;
                    end
                    if (got.done_res !== want.done_res) begin
                        $error("done_res expected %0d actual %0d",
                               want.done_res, got.done_res);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == REG_LOOP_ENABLE) loop_en = cfg_wdata[0];
                else fcount = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                mode = s_tuser;
                idx  = s_tdata[5:0];
                dur  = s_tdata[21:6];
                dt   = s_tdata[37:22];
                case (mode)
                    MODE_TICK: begin
                        advance_frames(dt);
                    end
                    MODE_WRITE: begin
                        dur_tbl[idx] = (dur == '0) ? DUR_W'(1) : dur;
                    end
                    MODE_RESTART: begin
                        cur_frame = '0;
                        spent = '0;
                        fin = 1'b0;
                    end
                    default: ;
                endcase
                want.frame_now     = cur_frame;
                want.time_in_frame = spent;
                want.done_res      = fin;
                expected_frames.insert(expected_frames.size(), want);
            end
        end
        results_owed = expected_frames.size();
    end

endmodule

@@ dv/tb_frame_duration_sequencer_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_duration_sequencer_top
// Drives the frame duration sequencer with a short directed sequence and then
// random phases of ticks, table writes and restarts under changing loop and
// frame count settings, with random gaps on both streams. Only table entries
// that have been written are ever stepped through. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_frame_duration_sequencer_top;
    import fds_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1080;
    localparam int IDLE_LIMIT   = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [6:0]  cfg_wdata;
    int          mismatch_count;
    int          results_owed;

    logic [DUR_W-1:0]  dur_seen [TABLE_LIM];
    bit                seen [TABLE_LIM];
    logic              loop_sh;
    logic [FCNT_W-1:0] fcount_sh;
    int                in_gap_pct;
    int                out_stall_pct;
    int                hold_cycles;
    int                idle_cycles;

    frame_duration_sequencer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fds_sequence_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic int gap_length();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < out_stall_pct) hold_cycles <= gap_length();
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_frame_duration_sequencer_top: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int frames_used();
        return (fcount_sh > TABLE_LIM) ? TABLE_LIM : int'(fcount_sh);
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 15) return 16'hFFFF;
        if (r < 25) return DUR_W'($urandom);
        return DUR_W'($urandom_range(1, 64));
    endfunction

    // keep the number of frames stepped per tick bounded
    function automatic logic [DUR_W-1:0] pick_dt();
        int n;
        int total;
        int cap;
        int r;
        n = frames_used();
        total = 0;
        for (int i = 0; i < n; i++) total += dur_seen[i];
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 15 && (!loop_sh || n == 0 || total >= 2048)) begin
            if ($urandom_range(0, 3) == 0) return 16'hFFFF;
            return DUR_W'($urandom);
        end
        cap = 2 * total + 1;
        if (cap > 65535) cap = 65535;
        return DUR_W'($urandom_range(1, cap));
    endfunction

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [FIDX_W-1:0] idx,
                             input logic [DUR_W-1:0] dur, input logic [DUR_W-1:0] dt);
        int gap;
        gap = ($urandom_range(0, 99) < in_gap_pct) ? gap_length() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  <= mode;
        s_tdata  <= {2'b00, dt, dur, idx};
        s_tvalid <= 1'b1;
        if (mode == MODE_WRITE) begin
            seen[idx] = 1'b1;
            dur_seen[idx] = (dur == '0) ? DUR_W'(1) : dur;
        end
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_reg(input logic idx, input logic [6:0] val);
        s_tvalid <= 1'b0;
        while (results_owed != 0) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        if (idx == REG_LOOP_ENABLE) loop_sh = val[0];
        else fcount_sh = val;
    endtask

    task automatic fill_table();
        for (int i = 0; i < frames_used(); i++) begin
            if (!seen[i]) send_item(MODE_WRITE, FIDX_W'(i), pick_duration(), DUR_W'($urandom));
        end
    endtask

    task automatic random_item(output bit counted);
        int r;
        r = $urandom_range(0, 99);
        counted = 1'b1;
        if (r < 60) begin
            send_item(MODE_TICK, FIDX_W'($urandom), DUR_W'($urandom), pick_dt());
        end else if (r < 85) begin
            send_item(MODE_WRITE, FIDX_W'($urandom_range(0, TABLE_LIM - 1)), pick_duration(),
                      DUR_W'($urandom));
        end else if (r < 95) begin
            send_item(MODE_RESTART, FIDX_W'($urandom), DUR_W'($urandom), DUR_W'($urandom));
        end else begin
            send_item(MODE_UNUSED, FIDX_W'($urandom), DUR_W'($urandom), DUR_W'($urandom));
            counted = 1'b0;
        end
    endtask

    initial begin
        int sent;
        int phase_len;
        int r;
        bit counted;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = '0;
        hold_cycles = 0;
        idle_cycles = 0;
        in_gap_pct = 30;
        out_stall_pct = 30;
        loop_sh = 1'b1;
        fcount_sh = FCNT_W'(1);
        for (int i = 0; i < TABLE_LIM; i++) begin
            seen[i] = 1'b0;
            dur_seen[i] = '0;
        end
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_item(MODE_UNUSED, 6'd63, 16'hFFFF, 16'hFFFF);
        send_item(MODE_RESTART, 6'd0, 16'd0, 16'd0);
        send_item(MODE_WRITE, 6'd0, 16'd0, 16'd0);
        send_item(MODE_TICK, 6'd0, 16'd0, 16'd0);
        send_item(MODE_TICK, 6'd0, 16'd0, 16'd1);
        send_item(MODE_WRITE, 6'd0, 16'hFFFF, 16'd0);
        send_item(MODE_TICK, 6'd0, 16'd0, 16'hFFFF);
        send_item(MODE_TICK, 6'd0, 16'd0, 16'hFFFE);
        // shrink the current frame below the time already spent in it
        send_item(MODE_WRITE, 6'd0, 16'd10, 16'd0);
        send_item(MODE_TICK, 6'd0, 16'd0, 16'd3);
        send_item(MODE_WRITE, 6'd63, 16'hFFFF, 16'hFFFF);
        send_item(MODE_WRITE, 6'd1, 16'd2, 16'd0);
        send_item(MODE_WRITE, 6'd2, 16'd3, 16'd0);
        send_item(MODE_WRITE, 6'd3, 16'd4, 16'd0);
        set_reg(REG_FRAME_COUNT, 7'd4);
        set_reg(REG_LOOP_ENABLE, 7'd0);
        send_item(MODE_TICK, 6'd0, 16'd0, 16'd9);
        send_item(MODE_TICK, 6'd0, 16'd0, 16'hFFFF);
        send_item(MODE_TICK, 6'd0, 16'd0, 16'd5);
        send_item(MODE_RESTART, 6'd0, 16'd0, 16'd0);
        send_item(MODE_TICK, 6'd0, 16'd0, 16'd15);
        // current frame now lies beyond the shortened sequence
        set_reg(REG_FRAME_COUNT, 7'd2);
        send_item(MODE_TICK, 6'd0, 16'd0, 16'd1);
        set_reg(REG_FRAME_COUNT, 7'd0);
        send_item(MODE_TICK, 6'd0, 16'd0, 16'd7);
        send_item(MODE_RESTART, 6'd0, 16'd0, 16'd0);
        set_reg(REG_LOOP_ENABLE, 7'd1);
        set_reg(REG_FRAME_COUNT, 7'd127);
        fill_table();
        send_item(MODE_TICK, 6'd0, 16'd0, 16'd100);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(40, 150);
            in_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            out_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            if ($urandom_range(0, 2) != 0) begin
                set_reg(REG_LOOP_ENABLE, 7'($urandom_range(0, 1)));
                r = $urandom_range(0, 99);
                if (r < 8) set_reg(REG_FRAME_COUNT, 7'd0);
                else if (r < 18) set_reg(REG_FRAME_COUNT, 7'd64);
                else if (r < 26) set_reg(REG_FRAME_COUNT, 7'($urandom_range(65, 127)));
                else if (r < 40) set_reg(REG_FRAME_COUNT, 7'd1);
                else if (r < 70) set_reg(REG_FRAME_COUNT, 7'($urandom_range(2, 8)));
                else set_reg(REG_FRAME_COUNT, 7'($urandom_range(9, 63)));
                fill_table();
            end
            for (int i = 0; i < phase_len; i++) begin
                random_item(counted);
                if (counted) sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (results_owed != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_frame_duration_sequencer_top: done, clean");
        end else begin
            $display("tb_frame_duration_sequencer_top: done, errors");
        end
        $finish;
    end

endmodule
